/* src/speck32_64_block_cipher_assert.svh */
// Assertion macros for the Speck32/64 cipher RTL.
// Used by spk_key_sched and speck32_64_block_cipher; no other dependencies.
`ifndef SPECK32_64_BLOCK_CIPHER_ASSERT_SVH
`define SPECK32_64_BLOCK_CIPHER_ASSERT_SVH
`ifndef SYNTH
// clocked on clk, disabled while rst_n is low
`define SPK_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m failed");
// clocked on clk, also checked during reset
`define SPK_ASSERT_NORST(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m failed");
`else
`define SPK_ASSERT(lbl, prop)
`define SPK_ASSERT_NORST(lbl, prop)
`endif
`endif

/* src/spk_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and round functions for the Speck32/64 cipher.
// No dependencies.
package spk_pkg;

    localparam int MAX_ROUNDS_DEF = 22;
    localparam int RESET_ROUNDS   = 22;
    localparam int ALPHA          = 7;
    localparam int BETA           = 2;
    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 64;

    localparam logic [CFG_IDX_W-1:0] REG_CIPHER_KEY  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_COUNT = 8'd1;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
    } word_pair_t;

    typedef struct packed {
        logic                  wr;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    typedef enum logic [1:0] {
        KS_LOAD,
        KS_RUN,
        KS_IDLE
    } ks_state_t;

    function automatic logic [15:0] rotr(input logic [15:0] v, input int n);
        rotr = (v >> n) | (v << (16 - n));
    endfunction

    function automatic logic [15:0] rotl(input logic [15:0] v, input int n);
        rotl = (v << n) | (v >> (16 - n));
    endfunction

    function automatic word_pair_t fwd_round(input logic [15:0] k, input word_pair_t d);
        word_pair_t r;
        r.x = (rotr(d.x, ALPHA) + d.y) ^ k;
        r.y = rotl(d.y, BETA) ^ r.x;
        fwd_round = r;
    endfunction

    function automatic word_pair_t inv_round(input logic [15:0] k, input word_pair_t d);
        word_pair_t r;
        r.y = rotr(d.y ^ d.x, BETA);
        r.x = rotl((d.x ^ k) - r.y, ALPHA);
        inv_round = r;
    endfunction

endpackage

/* src/spk_key_sched.sv */
`timescale 1ns / 1ps
// Key schedule: holds the cipher key and expands it into round keys,
// one round per cycle. Depends on spk_pkg and the assertion header.
`include "speck32_64_block_cipher_assert.svh"

module spk_key_sched #(
    parameter int MAX_ROUNDS = spk_pkg::MAX_ROUNDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  spk_pkg::cfg_wr_t    cfg,
    output logic                busy,
    output logic [15:0]         subkeys [MAX_ROUNDS]
);

    localparam int CW = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
    localparam logic [CW-1:0] CNT_LAST = CW'(MAX_ROUNDS - 2);

    spk_pkg::ks_state_t     state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [63:0]            cipher_key_reg;
    logic [15:0]            k_reg;
    logic [15:0]            l_reg [3];
    logic [15:0]            key_reg [MAX_ROUNDS];
    spk_pkg::word_pair_t    step;
    logic                   key_wr;

    assign key_wr = cfg.wr && (cfg.index == spk_pkg::REG_CIPHER_KEY);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            spk_pkg::KS_LOAD:
            begin
                cnt_next   = '0;
                state_next = (MAX_ROUNDS > 1) ? spk_pkg::KS_RUN : spk_pkg::KS_IDLE;
            end
            spk_pkg::KS_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = spk_pkg::KS_IDLE;
                end
            end
            spk_pkg::KS_IDLE:
            begin
                if (key_wr)
                begin
                    state_next = spk_pkg::KS_LOAD;
                end
            end
            default:
            begin
                state_next = spk_pkg::KS_LOAD;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            spk_pkg::KS_IDLE: busy = 1'b0;
            default:          busy = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= spk_pkg::KS_LOAD;
            cnt_reg        <= '0;
            cipher_key_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (key_wr && !busy)
            begin
                cipher_key_reg <= cfg.data;
            end
        end
    end

    assign step = spk_pkg::fwd_round(16'(cnt_reg), '{x: l_reg[0], y: k_reg});

    always_ff @(posedge clk)
    begin
        if (state_reg == spk_pkg::KS_LOAD)
        begin
            k_reg      <= cipher_key_reg[15:0];
            l_reg[0]   <= cipher_key_reg[31:16];
            l_reg[1]   <= cipher_key_reg[47:32];
            l_reg[2]   <= cipher_key_reg[63:48];
            key_reg[0] <= cipher_key_reg[15:0];
        end
        else if (state_reg == spk_pkg::KS_RUN)
        begin
            k_reg    <= step.y;
            l_reg[0] <= l_reg[1];
            l_reg[1] <= l_reg[2];
            l_reg[2] <= step.x;
            for (int j = 1; j < MAX_ROUNDS; j++)
            begin
                if (cnt_reg == CW'(j - 1))
                begin
                    key_reg[j] <= step.y;
                end
            end
        end
    end

    assign subkeys = key_reg;

    `SPK_ASSERT(a_key_wr_restarts, key_wr && !busy |=> state_reg == spk_pkg::KS_LOAD)
    `SPK_ASSERT(a_cnt_in_range, state_reg == spk_pkg::KS_RUN |-> cnt_reg <= CNT_LAST)

endmodule

/* src/speck32_64_block_cipher.sv */
`timescale 1ns / 1ps
// Speck32/64 cipher, at most one round per pipeline stage, MAX_ROUNDS stages.
// One block per cycle through MAX_ROUNDS stage registers unless stalled by m_tready or ks_busy.
// After reset and after each key write the key schedule expands the
// round keys, one round key a cycle; s_tready and cfg_ready stay low meanwhile.
// Reset clears valid bits, sets key to 0 and round count to 22 (MAX_ROUNDS if smaller).
// Depends on spk_pkg, spk_key_sched and the assertion header.
`include "speck32_64_block_cipher_assert.svh"

module speck32_64_block_cipher #(
    parameter int MAX_ROUNDS = spk_pkg::MAX_ROUNDS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // block_in
    input  logic [0:0]                      s_tuser,   // opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // block_out
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [spk_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [spk_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int NW = $clog2(MAX_ROUNDS + 1);
    localparam int RST_N_INT = (spk_pkg::RESET_ROUNDS > MAX_ROUNDS) ?
                               MAX_ROUNDS : spk_pkg::RESET_ROUNDS;

    spk_pkg::cfg_wr_t       cfg;
    logic                   ks_busy;
    logic [15:0]            subkeys [MAX_ROUNDS];
    logic [NW-1:0]          n_reg;
    logic [4:0]             rc_raw;

    logic [MAX_ROUNDS:0]    open_w;
    logic                   v_reg  [MAX_ROUNDS];
    logic                   op_reg [MAX_ROUNDS];
    spk_pkg::word_pair_t    d_reg  [MAX_ROUNDS];

    assign cfg_ready = !ks_busy;
    assign cfg.wr    = cfg_valid && cfg_ready;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    spk_key_sched #(
        .MAX_ROUNDS (MAX_ROUNDS)
    ) u_key_sched (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .busy       (ks_busy),
        .subkeys    (subkeys)
    );

    assign rc_raw = cfg_data[4:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= NW'(RST_N_INT);
        end
        else if (cfg.wr && (cfg_index == spk_pkg::REG_ROUND_COUNT))
        begin
            if (rc_raw == 5'd0)
            begin
                n_reg <= NW'(1);
            end
            else if (int'(rc_raw) > MAX_ROUNDS)
            begin
                n_reg <= NW'(MAX_ROUNDS);
            end
            else
            begin
                n_reg <= NW'(rc_raw);
            end
        end
    end

    // a stage may load when it is empty or everything after it moves
    assign open_w[MAX_ROUNDS] = m_tready;
    assign s_tready = open_w[0] && !ks_busy;

    for (genvar s = 0; s < MAX_ROUNDS; s++)
    begin : g_stage
        localparam logic [NW-1:0] ENC_LIM = NW'(s);
        localparam int            DEC_KEY = MAX_ROUNDS - 1 - s;
        localparam logic [NW-1:0] DEC_LIM = NW'(DEC_KEY);

        logic                   v_in;
        logic                   op_in;
        spk_pkg::word_pair_t    d_in;
        spk_pkg::word_pair_t    d_next;

        assign open_w[s] = !v_reg[s] || open_w[s+1];

        if (s == 0)
        begin : g_first
            assign v_in  = s_tvalid && !ks_busy;
            assign op_in = s_tuser[0];
            assign d_in  = s_tdata;
        end
        else
        begin : g_rest
            assign v_in  = v_reg[s-1];
            assign op_in = op_reg[s-1];
            assign d_in  = d_reg[s-1];
        end

        // encrypt fills the first n stages, decrypt the last n
        always_comb
        begin
            d_next = d_in;
            if (op_in)
            begin
                if (n_reg > DEC_LIM)
                begin
                    d_next = spk_pkg::inv_round(subkeys[DEC_KEY], d_in);
                end
            end
            else if (n_reg > ENC_LIM)
            begin
                d_next = spk_pkg::fwd_round(subkeys[s], d_in);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (open_w[s])
            begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (open_w[s] && v_in)
            begin
                op_reg[s] <= op_in;
                d_reg[s]  <= d_next;
            end
        end
    end

    assign m_tvalid = v_reg[MAX_ROUNDS-1];
    assign m_tdata  = d_reg[MAX_ROUNDS-1];

    `SPK_ASSERT(a_no_accept_busy, ks_busy |-> !s_tready && !cfg_ready)
    `SPK_ASSERT(a_accept_fills_first, s_tvalid && s_tready |=> v_reg[0])
    `SPK_ASSERT(a_rounds_in_range, n_reg != '0 && int'(n_reg) <= MAX_ROUNDS)
    `SPK_ASSERT_NORST(a_reset_empty, !rst_n |=> !m_tvalid)

endmodule
